### sv/vtcm_pkg.sv
// ----------------------------------------------------------------------------
// vtcm_pkg
// shared constants, codes and types of the value to color map block
// ----------------------------------------------------------------------------
package vtcm_pkg;

  // color table and value sizes
  localparam int TABLE_DEPTH = 256;
  localparam int VALUE_BITS  = 32;
  localparam int AW          = $clog2(TABLE_DEPTH);
  localparam int VW          = VALUE_BITS;
  localparam int DW          = VW + 2;          // width of value differences
  localparam int CW          = 24;              // packed rgb color
  localparam int MS_BITS     = 9;               // map size register

  // q0.16 fraction, one integer bit so that 1.0 fits
  localparam int FB          = 16;
  localparam int TW          = FB + 1;
  localparam int XW          = TW + AW;         // table position, q.16
  localparam logic [TW-1:0] T_ONE  = TW'(65536);
  localparam logic [TW-1:0] T_HALF = TW'(32768);

  localparam logic signed [VW-1:0] V_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] V_MIN = {1'b1, {(VW-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_SCAN  = 2'd1,
    OP_COLOR = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CFG_START    = 3'd0,
    CFG_END      = 3'd1,
    CFG_AUTO     = 3'd2,
    CFG_SYM      = 3'd3,
    CFG_ONLY_SEL = 3'd4,
    CFG_MAP_SIZE = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RANGE,
    S_DIFF,
    S_FRAC,
    S_RD0,
    S_RD1,
    S_RD2,
    S_BLEND,
    S_OUT
  } state_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_PREP,
    F_CMP,
    F_DIV
  } frac_state_e;

  typedef struct packed {
    logic          done;
    logic [TW-1:0] t;
  } frac_res_t;

endpackage

### sv/vtcm_table_ram.sv
// ----------------------------------------------------------------------------
// vtcm_table_ram
// color table, one write port and one registered read port
// ----------------------------------------------------------------------------
module vtcm_table_ram (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [vtcm_pkg::AW-1:0] waddr_i,
  input  logic [vtcm_pkg::CW-1:0] wdata_i,
  input  logic                    re_i,
  input  logic [vtcm_pkg::AW-1:0] raddr_i,
  output logic [vtcm_pkg::CW-1:0] rdata_o
);
  import vtcm_pkg::*;

  logic [CW-1:0] mem_q [TABLE_DEPTH];
  logic [CW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/vtcm_frac_div.sv
// ----------------------------------------------------------------------------
// vtcm_frac_div
// clamped fraction num/den as q0.16, radix-2 restoring divider
// ----------------------------------------------------------------------------
module vtcm_frac_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic signed [vtcm_pkg::DW-1:0] num_i,
  input  logic signed [vtcm_pkg::DW-1:0] den_i,
  output vtcm_pkg::frac_res_t            res_o
);
  import vtcm_pkg::*;

  localparam int MW = DW - 1;   // magnitude width
  localparam int NW = $clog2(FB);

  frac_state_e state_q, state_d;
  logic signed [DW-1:0] num_q, num_d, den_q, den_d;
  logic signed [DW-1:0] num_abs, den_abs;
  logic [MW-1:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [MW:0]   rem_sh;
  logic [FB-1:0] quo_q, quo_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic [TW-1:0] t_q, t_d;

  assign num_abs = num_q[DW-1] ? -num_q : num_q;
  assign den_abs = den_q[DW-1] ? -den_q : den_q;
  assign rem_sh  = {rem_q, 1'b0};

  always_comb begin
    state_d = state_q;
    num_d   = num_q;
    den_d   = den_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    t_d     = t_q;
    case (state_q)
      F_IDLE: begin
        if (start_i) begin
          num_d   = num_i;
          den_d   = den_i;
          state_d = F_PREP;
        end
      end
      F_PREP: begin
        if (den_q == '0) begin
          // zero-length range: half on the point, full above, none below
          if (num_q == '0) begin
            t_d = T_HALF;
          end else if (!num_q[DW-1]) begin
            t_d = T_ONE;
          end else begin
            t_d = '0;
          end
          done_d  = 1'b1;
          state_d = F_IDLE;
        end else if (num_q == '0 || (num_q[DW-1] != den_q[DW-1])) begin
          t_d     = '0;
          done_d  = 1'b1;
          state_d = F_IDLE;
        end else begin
          rem_d   = MW'(num_abs);
          dvs_d   = MW'(den_abs);
          state_d = F_CMP;
        end
      end
      F_CMP: begin
        if (rem_q >= dvs_q) begin
          t_d     = T_ONE;
          done_d  = 1'b1;
          state_d = F_IDLE;
        end else begin
          quo_d   = '0;
          cnt_d   = '0;
          state_d = F_DIV;
        end
      end
      F_DIV: begin
        if (rem_sh >= {1'b0, dvs_q}) begin
          rem_d = MW'(rem_sh - {1'b0, dvs_q});
          quo_d = {quo_q[FB-2:0], 1'b1};
        end else begin
          rem_d = MW'(rem_sh);
          quo_d = {quo_q[FB-2:0], 1'b0};
        end
        if (cnt_q == NW'(FB-1)) begin
          t_d     = {1'b0, quo_d};
          done_d  = 1'b1;
          state_d = F_IDLE;
        end else begin
          cnt_d = cnt_q + NW'(1);
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
    t_q   <= t_d;
  end

  assign res_o.done = done_q;
  assign res_o.t    = t_q;

endmodule

### sv/value_to_color_map.sv
// ----------------------------------------------------------------------------
// value_to_color_map
// maps a signed value to an rgb color by blending two color table entries
// ----------------------------------------------------------------------------
// Each input word carries one operation. A load writes one packed rgb entry
// into the color table, a scan folds the value into a running min/max, a
// clear resets that scan, and a color word returns one red/green/blue result.
// The value is placed in its range as t = (value - start) / (end - start),
// a q0.16 fraction clamped to [0, 1]; the range comes from the start/end
// registers, or from the scan when auto range is set (symmetric about zero
// if asked, the full signed range when nothing was scanned). t times
// (map size - 1) selects two adjacent entries that are blended per channel.
// Load, scan and clear words are taken in idle and leave the block idle. A
// color word keeps the block busy, mostly in the 16-step radix-2 divider,
// skipped when the fraction is settled without dividing (zero range, value
// at or beyond an end of the range). The two table entries are fetched one
// after the other over the single read port of the table memory, and the
// three channels are blended one per cycle. A finished color sits in the
// output register, so the next word is accepted while it waits. The table
// has no reset: every entry that a color word can reach must be loaded first.
// The user must write configuration only while idle; it is not enforced.
// ----------------------------------------------------------------------------
module value_to_color_map (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] value_i,
  input  logic        selected_i,
  input  logic [7:0]  table_index_i,
  input  logic [23:0] table_color_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import vtcm_pkg::*;

  localparam int NUM_CH = 3;

  // configuration registers
  logic signed [VW-1:0] cfg_start_q, cfg_end_q;
  logic                 cfg_auto_q, cfg_sym_q, cfg_only_sel_q;
  logic [MS_BITS-1:0]   cfg_map_size_q;

  // running scan
  logic signed [VW-1:0] scan_min_q, scan_max_q;
  logic                 scan_seen_q;

  // sequencer and datapath
  state_e state_q, state_d;
  logic signed [VW-1:0] v_in, v_q;
  logic signed [VW:0]   s_sel, e_sel, s_q, e_q;
  logic signed [VW:0]   s_abs, e_abs, r_max;
  logic                 sym_sel, sym_q;
  logic signed [DW-1:0] num, den;
  logic [XW-1:0]        x_q;
  logic [AW-1:0]        nm1, x0, x1;
  logic [CW-1:0]        c0_q, c1_q, rgb_q;
  logic [1:0]           bcnt_q;
  logic [FB-1:0]        f;
  logic [TW-1:0]        w0, w1;
  logic [TW+8:0]        blend_sum;
  logic [7:0]           ch;

  // handshakes and strobes
  op_e       op;
  logic      accept, skip, frac_start, ram_we, ram_re, out_load;
  logic [AW-1:0] ram_raddr;
  logic [CW-1:0] ram_rdata;
  frac_res_t frac_res;

  logic       out_valid_q;
  logic [7:0] red_q, green_q, blue_q;

  assign op         = op_e'(operation_i);
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign skip       = cfg_only_sel_q && !selected_i;
  assign v_in       = value_i[VW-1:0];

  // config writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_start_q    <= '0;
      cfg_end_q      <= '0;
      cfg_auto_q     <= 1'b0;
      cfg_sym_q      <= 1'b0;
      cfg_only_sel_q <= 1'b0;
      cfg_map_size_q <= MS_BITS'(256);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_START:    cfg_start_q    <= cfg_data_i[VW-1:0];
        CFG_END:      cfg_end_q      <= cfg_data_i[VW-1:0];
        CFG_AUTO:     cfg_auto_q     <= cfg_data_i[0];
        CFG_SYM:      cfg_sym_q      <= cfg_data_i[0];
        CFG_ONLY_SEL: cfg_only_sel_q <= cfg_data_i[0];
        CFG_MAP_SIZE: cfg_map_size_q <= cfg_data_i[MS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // scan min/max, updated when the word is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_min_q  <= V_MAX;
      scan_max_q  <= V_MIN;
      scan_seen_q <= 1'b0;
    end else if (accept) begin
      if (op == OP_CLEAR) begin
        scan_min_q  <= V_MAX;
        scan_max_q  <= V_MIN;
        scan_seen_q <= 1'b0;
      end else if (op == OP_SCAN && !skip) begin
        if (v_in < scan_min_q) begin
          scan_min_q <= v_in;
        end
        if (v_in > scan_max_q) begin
          scan_max_q <= v_in;
        end
        scan_seen_q <= 1'b1;
      end
    end
  end

  // range picked at accept time, sign extended by one bit so -r fits later
  always_comb begin
    if (cfg_auto_q) begin
      if (scan_seen_q) begin
        s_sel = {scan_min_q[VW-1], scan_min_q};
        e_sel = {scan_max_q[VW-1], scan_max_q};
      end else begin
        s_sel = {V_MIN[VW-1], V_MIN};
        e_sel = {V_MAX[VW-1], V_MAX};
      end
    end else begin
      s_sel = {cfg_start_q[VW-1], cfg_start_q};
      e_sel = {cfg_end_q[VW-1], cfg_end_q};
    end
  end
  assign sym_sel = cfg_auto_q && scan_seen_q && cfg_sym_q;

  // symmetric range: -r..r with r the larger magnitude
  assign s_abs = s_q[VW] ? -s_q : s_q;
  assign e_abs = e_q[VW] ? -e_q : e_q;
  assign r_max = (s_abs > e_abs) ? s_abs : e_abs;

  // differences handed to the divider
  assign num = {v_q[VW-1], v_q[VW-1], v_q} - {s_q[VW], s_q};
  assign den = {e_q[VW], e_q} - {s_q[VW], s_q};

  // entries in use minus one, map size clamped to [2, depth]
  always_comb begin
    if (cfg_map_size_q < MS_BITS'(2)) begin
      nm1 = AW'(1);
    end else if (32'(cfg_map_size_q) > TABLE_DEPTH) begin
      nm1 = AW'(TABLE_DEPTH - 1);
    end else begin
      nm1 = AW'(cfg_map_size_q - MS_BITS'(1));
    end
  end

  // table position: integer part picks the entries, fraction blends them
  assign x0 = x_q[FB+AW-1:FB];
  assign x1 = (x0 < nm1) ? x0 + AW'(1) : x0;
  assign f  = x_q[FB-1:0];

  // one channel per cycle, top byte of the shifting color pair
  assign w1        = {1'b0, f};
  assign w0        = T_ONE - w1;
  assign blend_sum = (TW+9)'((TW+9)'(c0_q[CW-1 -: 8]) * (TW+9)'(w0))
                   + (TW+9)'((TW+9)'(c1_q[CW-1 -: 8]) * (TW+9)'(w1))
                   + (TW+9)'(T_HALF);
  assign ch        = blend_sum[FB+7:FB];

  // sequencer
  always_comb begin
    state_d    = state_q;
    frac_start = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = x0;
    out_load   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept && op == OP_COLOR && !skip) begin
          state_d = S_RANGE;
        end
      end
      S_RANGE: begin
        state_d = S_DIFF;
      end
      S_DIFF: begin
        frac_start = 1'b1;
        state_d    = S_FRAC;
      end
      S_FRAC: begin
        if (frac_res.done) begin
          state_d = S_RD0;
        end
      end
      S_RD0: begin
        ram_re    = 1'b1;
        ram_raddr = x0;
        state_d   = S_RD1;
      end
      S_RD1: begin
        ram_re    = 1'b1;
        ram_raddr = x1;
        state_d   = S_RD2;
      end
      S_RD2: begin
        state_d = S_BLEND;
      end
      S_BLEND: begin
        if (bcnt_q == 2'(NUM_CH - 1)) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        // wait only while the previous color is still held
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      bcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_RD2) begin
        bcnt_q <= '0;
      end else if (state_q == S_BLEND) begin
        bcnt_q <= bcnt_q + 2'd1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          v_q   <= v_in;
          s_q   <= s_sel;
          e_q   <= e_sel;
          sym_q <= sym_sel;
        end
      end
      S_RANGE: begin
        if (sym_q) begin
          s_q <= -r_max;
          e_q <= r_max;
        end
      end
      S_FRAC: begin
        if (frac_res.done) begin
          x_q <= XW'(frac_res.t) * XW'(nm1);
        end
      end
      S_RD1: begin
        c0_q <= ram_rdata;
      end
      S_RD2: begin
        c1_q <= ram_rdata;
      end
      S_BLEND: begin
        c0_q  <= c0_q << 8;
        c1_q  <= c1_q << 8;
        rgb_q <= {rgb_q[CW-9:0], ch};
      end
      default: ;
    endcase
  end

  // table writes only happen in idle, reads only later: no overlap
  assign ram_we = accept && op == OP_LOAD && (32'(table_index_i) < TABLE_DEPTH);

  vtcm_table_ram u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(table_index_i)),
    .wdata_i (table_color_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  vtcm_frac_div u_frac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (frac_start),
    .num_i   (num),
    .den_i   (den),
    .res_o   (frac_res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      red_q   <= rgb_q[23:16];
      green_q <= rgb_q[15:8];
      blue_q  <= rgb_q[7:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

  // checks
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_OUT))
    else $error("result word raised outside the output step");

  a_frac_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frac_res.done |-> state_q == S_FRAC)
    else $error("divider finished while the sequencer was not waiting");

  a_frac_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frac_res.done |-> frac_res.t <= T_ONE)
    else $error("fraction above one");

  a_scan_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_seen_q |-> scan_min_q <= scan_max_q)
    else $error("scan minimum above scan maximum");

endmodule
